>>> sv/wepr_pkg.sv
// ----------------------------------------------------------------------------
// wepr_pkg
// Shared constants for the windowed event profile histogram: request codes,
// event kinds, filter modes, register indexes and the fixed window geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package wepr_pkg;

    // Default store geometry
    localparam int NUM_BINS_DEF    = 2048;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed window geometry, in pixels
    localparam int CENTER_COL = 71;
    localparam int HALF_SPAN  = 60;
    localparam int CENTER_ROW = 71;

    // Column window in tenths: [LO_COL, HI_COL)
    localparam int LO_COL = 10 * (CENTER_COL - HALF_SPAN) - 5;
    localparam int HI_COL = 10 * (CENTER_COL + HALF_SPAN) + 5;

    // Request codes
    localparam logic [1:0] REQ_EVENT      = 2'd0;
    localparam logic [1:0] REQ_READ       = 2'd1;
    localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

    // Counted event kinds
    localparam logic [7:0] KIND_SINGLE_A    = 8'd10;
    localparam logic [7:0] KIND_SINGLE_B    = 8'd11;
    localparam logic [7:0] KIND_SIDE_DOUBLE = 8'd22;

    // Filter modes
    localparam logic [1:0] MODE_ALL_KINDS   = 2'd1;
    localparam logic [1:0] MODE_SIDE_DOUBLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_EVENT_MODE    = 2'd0;
    localparam logic [1:0] CFG_ENERGY_MIN    = 2'd1;
    localparam logic [1:0] CFG_ENERGY_MAX    = 2'd2;
    localparam logic [1:0] CFG_PROFILE_WIDTH = 2'd3;

    // Configuration reset values
    localparam logic [1:0]  EVENT_MODE_RST    = 2'd1;
    localparam logic [11:0] ENERGY_MIN_RST    = 12'd50;
    localparam logic [11:0] ENERGY_MAX_RST    = 12'd100;
    localparam logic [7:0]  PROFILE_WIDTH_RST = 8'd40;

    // Pending operation carried from the read cycle to the write-back cycle
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

`default_nettype wire

>>> sv/wepr_ram.sv
// ----------------------------------------------------------------------------
// wepr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module wepr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/windowed_event_profile_histogram_core.sv
// ----------------------------------------------------------------------------
// windowed_event_profile_histogram_core
// Qualifies detector events against kind, column, row and pulse-height
// windows and counts them into a column profile held in one RAM.
// ----------------------------------------------------------------------------
// For each input word, in the cycle it is accepted the windows are checked
// and the bin is read from the profile RAM; then, in the write-back state, the
// count is incremented (saturating) or the bin is read back and optionally
// cleared, the RAM is written and the result word is loaded into the output
// register. The single read-modify-write of the profile RAM sets the pace:
// a new word is taken only once the previous one has written back, so no two
// accesses to one bin ever overlap. A result waiting on a stalled output
// holds the write-back stage until it leaves. After reset the block sweeps the
// RAM once to zero it, one bin per cycle, and holds in_stall high meanwhile;
// configuration writes are taken at any time. Every word yields exactly one
// result word: rejected events and unknown requests give all zeros, reads
// of an in-range bin give the bin and its count.
`default_nettype none

module windowed_event_profile_histogram_core
    import wepr_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  event_kind,
    input  wire logic [10:0] column_tenths,
    input  wire logic [10:0] row_tenths,
    input  wire logic [15:0] pulse_tenths,
    input  wire logic [10:0] bin_select,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic [10:0]      bin_index,
    output logic [31:0]      bin_count
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic signed [15:0] LO_COL_S = 16'(LO_COL);
    localparam logic signed [15:0] HI_COL_S = 16'(HI_COL);
    localparam logic signed [15:0] CENTER_ROW_S = 16'(CENTER_ROW);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_ACCESS = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  event_mode_reg;
    logic [11:0] energy_min_reg;
    logic [11:0] energy_max_reg;
    logic [7:0]  profile_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_mode_reg    <= EVENT_MODE_RST;
            energy_min_reg    <= ENERGY_MIN_RST;
            energy_max_reg    <= ENERGY_MAX_RST;
            profile_width_reg <= PROFILE_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EVENT_MODE:    event_mode_reg    <= cfg_data[1:0];
                CFG_ENERGY_MIN:    energy_min_reg    <= cfg_data;
                CFG_ENERGY_MAX:    energy_max_reg    <= cfg_data;
                CFG_PROFILE_WIDTH: profile_width_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    op_t             op_reg, op_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [10:0]     idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic            accepted_reg, accepted_next;
    logic [10:0]     bin_index_reg, bin_index_next;
    logic [31:0]     bin_count_reg, bin_count_next;

    logic in_fire;
    logic out_fire;
    logic finish;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    // Write back only when the output register is free or drains this cycle
    assign finish   = (state_reg == ST_ACCESS) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Event qualification, evaluated in the accept cycle
    // ------------------------------------------------------------------
    logic               kind_ok;
    logic signed [15:0] col_s;
    logic signed [15:0] bin_s;
    logic               col_ok;
    logic [7:0]         half_w;
    logic signed [15:0] lo_row;
    logic signed [15:0] hi_row;
    logic signed [15:0] row_s;
    logic               row_ok;
    logic [16:0]        emin_t;
    logic [16:0]        emax_t;
    logic               pulse_ok;
    logic               event_ok;
    logic               sel_in_range;

    always_comb
    begin
        case (event_mode_reg)
            MODE_ALL_KINDS:
                kind_ok = event_kind inside {KIND_SINGLE_A, KIND_SINGLE_B, KIND_SIDE_DOUBLE};
            MODE_SIDE_DOUBLE:
                kind_ok = (event_kind == KIND_SIDE_DOUBLE);
            default:
                kind_ok = 1'b0;
        endcase
    end

    assign col_s  = $signed({5'd0, column_tenths});
    assign col_ok = (col_s >= LO_COL_S) && (col_s < HI_COL_S);
    assign bin_s  = col_s - LO_COL_S;

    // Even width w: span CENTER_ROW +/- w/2. Odd width: -(w+1)/2 .. +(w+1)/2-1.
    assign half_w = 8'(({1'b0, profile_width_reg} + 9'd1) >> 1);
    assign lo_row = 16'(16'(CENTER_ROW_S - $signed({8'd0, half_w})) * 16'sd10);
    assign hi_row = 16'(16'(CENTER_ROW_S + $signed({8'd0, half_w})
                            - $signed({15'd0, profile_width_reg[0]})) * 16'sd10);
    assign row_s  = $signed({5'd0, row_tenths});
    assign row_ok = (row_s >= lo_row) && (row_s <= hi_row);

    assign emin_t   = 17'(17'(energy_min_reg) * 17'd10);
    assign emax_t   = 17'(17'(energy_max_reg) * 17'd10);
    assign pulse_ok = ({1'b0, pulse_tenths} >= emin_t) && ({1'b0, pulse_tenths} <= emax_t);

    assign event_ok = kind_ok && col_ok && row_ok && pulse_ok
                      && ($unsigned(bin_s) < 16'(NUM_BINS));

    assign sel_in_range = (13'(bin_select) < 13'(NUM_BINS));

    // ------------------------------------------------------------------
    // Profile RAM
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] count_inc;

    assign count_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(bin_select);
        if (in_fire)
        begin
            if (req_type == REQ_EVENT)
            begin
                ram_re    = event_ok;
                ram_raddr = bin_s[AW-1:0];
            end
            else if (req_type == REQ_READ || req_type == REQ_READ_CLEAR)
            begin
                ram_re = sel_in_range;
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
        end
        else if (finish)
        begin
            ram_we    = (op_reg == OP_COUNT) || (op_reg == OP_CLEAR);
            ram_wdata = (op_reg == OP_COUNT) ? count_inc : '0;
        end
    end

    wepr_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_profile_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_fire;
        accepted_next  = accepted_reg;
        bin_index_next = bin_index_reg;
        bin_count_next = bin_count_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NUM_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_ACCESS;
                    idx_next   = bin_select;
                    addr_next  = ram_raddr;
                    case (req_type)
                        REQ_EVENT:
                        begin
                            op_next  = event_ok ? OP_COUNT : OP_NONE;
                            idx_next = event_ok ? bin_s[10:0] : 11'd0;
                        end
                        REQ_READ:       op_next = sel_in_range ? OP_READ : OP_NONE;
                        REQ_READ_CLEAR: op_next = sel_in_range ? OP_CLEAR : OP_NONE;
                        default:
                        begin
                            op_next  = OP_NONE;
                            idx_next = 11'd0;
                        end
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    accepted_next  = (op_reg == OP_COUNT);
                    bin_index_next = idx_reg;
                    case (op_reg)
                        OP_COUNT:           bin_count_next = 32'(count_inc);
                        OP_READ, OP_CLEAR:  bin_count_next = 32'(ram_rdata);
                        default:            bin_count_next = 32'd0;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        accepted_reg  <= accepted_next;
        bin_index_reg <= bin_index_next;
        bin_count_reg <= bin_count_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign bin_index = bin_index_reg;
    assign bin_count = bin_count_reg;

`ifndef SYNTHESIS
    // No word enters while the RAM is being swept
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("word accepted during clearing sweep");

    // A new result appears only out of the write-back stage
    a_result_from_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_ACCESS))
        else $error("result raised outside write-back");

    // A counted event never reports a zero count
    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (bin_count != 32'd0))
        else $error("counted event with zero count");

    // Read and write-back never share a cycle, so no bin is accessed twice at once
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && ram_we))
        else $error("RAM read and write overlap");
`endif

endmodule

`default_nettype wire
